FILE: design/aes_pkg.sv
package aes_pkg;

  localparam int ROUND_COUNT_DEF = 14;
  localparam int BLOCK_W = 128;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR  = 3'd4;

  localparam logic FUNC_IV = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // Forward S-box
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    return t[x];
  endfunction

  // Inverse S-box
  function automatic logic [7:0] sbox_rev(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // Byte i of the block sits in bits 127-8i downto 120-8i.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127-8*(4*c+w) -: 8] = sbox(s[127-8*(4*((c+w)%4)+w) -: 8]);
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127-8*(4*c+w) -: 8] = sbox_rev(s[127-8*(4*((c-w+4)%4)+w) -: 8]);
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      r[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      r[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      r[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      r[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return r;
  endfunction

  // Inverse mix: pre-multiply by {05,00,04,00} pattern, then forward mix.
  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] p;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      p[127-32*c -: 8] = a0 ^ u;
      p[119-32*c -: 8] = a1 ^ v;
      p[111-32*c -: 8] = a2 ^ u;
      p[103-32*c -: 8] = a3 ^ v;
    end
    return mix(p);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

FILE: design/aes256_cbc_cipher.sv
// AES-256 CBC cipher. Write the key as four 64-bit words (index 0..3) and the
// direction (index 4) while idle; a key write forces a key expansion before
// the next data word. An IV word (func 0) loads the chaining register and,
// when encrypting, is echoed as output. A data word passes through the initial
// key addition, 14 rounds and the output, one round per cycle against a
// 15-entry round-key RAM whose one read port is prefetched a cycle ahead.
// One word is in flight at a time; the next is accepted as soon as the result
// register is free or being taken.
module aes256_cbc_cipher
  import aes_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [63:0]           in_block_hi,
  input  logic [63:0]           in_block_lo,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_out_hi,
  output logic [63:0]           out_out_lo
);

  logic [255:0] key_r;
  logic         dir_r;
  logic         dirty_r;
  logic [127:0] chain_r;
  logic         act_r, act_dir_r;
  logic [127:0] act_in_r;
  logic         ov_r;
  logic [127:0] o_r;
  logic         in_acc, out_acc, start, busy, done;
  logic [127:0] in_blk, res, core_in;

  assign in_blk = {in_block_hi, in_block_lo};
  assign out_acc = ov_r && !out_stall;
  assign in_stall = act_r || (ov_r && out_stall);
  assign in_acc = in_valid && !in_stall;
  assign start = in_acc && (in_func == FUNC_DATA);
  assign core_in = dir_r ? in_blk : (in_blk ^ chain_r);

  aes_cbc_core #(.ROUND_COUNT(ROUND_COUNT)) u_core (
    .clk(clk), .rst_n(rst_n), .key_dirty(dirty_r), .key(key_r), .dir(dir_r),
    .start(start), .blk(core_in), .busy(busy), .done(done), .res(res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      dir_r <= 1'b0;
      dirty_r <= 1'b1;
    end else begin
      if (start) dirty_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY0: begin key_r[255:192] <= cfg_data; dirty_r <= 1'b1; end
          REG_KEY1: begin key_r[191:128] <= cfg_data; dirty_r <= 1'b1; end
          REG_KEY2: begin key_r[127:64]  <= cfg_data; dirty_r <= 1'b1; end
          REG_KEY3: begin key_r[63:0]    <= cfg_data; dirty_r <= 1'b1; end
          REG_DIR:  dir_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Track the word in the core, update chain, hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
      act_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (out_acc) ov_r <= 1'b0;
      if (in_acc && in_func == FUNC_IV) begin
        chain_r <= in_blk;
        if (!dir_r) begin
          ov_r <= 1'b1;
          o_r <= in_blk;
        end
      end
      if (start) begin
        act_r <= 1'b1;
        act_dir_r <= dir_r;
        act_in_r <= in_blk;
      end
      if (done) begin
        act_r <= 1'b0;
        ov_r <= 1'b1;
        if (act_dir_r) begin
          o_r <= res ^ chain_r;
          chain_r <= act_in_r;
        end else begin
          o_r <= res;
          chain_r <= res;
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_out_hi = o_r[127:64];
  assign out_out_lo = o_r[63:0];

  a_busy: assert property (@(posedge clk) disable iff (!rst_n) act_r |-> busy || done)
    else $error("word in flight but core idle");
  a_done: assert property (@(posedge clk) disable iff (!rst_n) done |-> act_r)
    else $error("core finished with no word");
  a_nostart: assert property (@(posedge clk) disable iff (!rst_n) busy |-> !start)
    else $error("word accepted while core busy");

endmodule

FILE: design/aes_ram.sv
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/aes_cbc_core.sv
module aes_cbc_core
  import aes_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                key_dirty,
  input  logic [255:0]                        key,
  input  logic                                dir,
  input  logic                                start,
  input  logic [127:0]                        blk,
  output logic                                busy,
  output logic                                done,
  output logic [127:0]                        res
);

  localparam int RK_N = ROUND_COUNT + 1;
  localparam int AW = $clog2(RK_N);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXP  = 3'd1;
  localparam logic [2:0] ST_PRE  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]     st_r, st_nxt;
  logic           ready_r;
  logic           done_r;
  logic [AW-1:0]  cnt_r;
  logic [127:0]   s_r;
  logic [255:0]   w_r;
  logic [7:0]     rc_r;
  logic [127:0]   rk, rk_mem;
  logic           fwd_r;
  logic [127:0]   fwd_d_r;
  logic           we;
  logic [AW-1:0]  wa, ra;
  logic [127:0]   wd;
  logic [31:0]    t0, t4;
  logic [127:0]   nl, nh;
  logic [127:0]   enc_r, dec_r;

  aes_ram #(.WIDTH(128), .DEPTH(RK_N)) u_rk (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd),
    .rd_addr(ra), .rd_data(rk_mem)
  );

  // Forward a key written at the same edge it is read
  assign rk = fwd_r ? fwd_d_r : rk_mem;

  // Next pair of round keys from the 8-word window
  always_comb begin
    t0 = sub_word({w_r[23:0], w_r[31:24]}) ^ {rc_r, 24'h0};
    nl[127:96] = w_r[255:224] ^ t0;
    nl[95:64]  = w_r[223:192] ^ nl[127:96];
    nl[63:32]  = w_r[191:160] ^ nl[95:64];
    nl[31:0]   = w_r[159:128] ^ nl[63:32];
    t4 = sub_word(nl[31:0]);
    nh[127:96] = w_r[127:96] ^ t4;
    nh[95:64]  = nh[127:96] ^ w_r[95:64];
    nh[63:32]  = nh[95:64] ^ w_r[63:32];
    nh[31:0]   = nh[63:32] ^ w_r[31:0];
  end

  // Round-key write during expansion: even entries from the window high half
  always_comb begin
    we = (st_r == ST_EXP);
    wa = cnt_r;
    wd = cnt_r[0] ? w_r[127:0] : w_r[255:128];
  end

  // Prefetch the key for the next cycle's round
  always_comb begin
    ra = '0;
    if (st_r == ST_IDLE) begin
      ra = dir ? AW'(ROUND_COUNT) : '0;
    end else if (st_r == ST_PRE) begin
      ra = dir ? AW'(ROUND_COUNT - 1) : AW'(1);
    end else if (st_r == ST_RND) begin
      ra = dir ? cnt_r - AW'(1) : cnt_r + AW'(1);
    end else if (st_r == ST_EXP) begin
      ra = dir ? AW'(ROUND_COUNT) : '0;
    end
  end

  always_comb begin
    enc_r = mix(sub_shift(s_r)) ^ rk;
    dec_r = inv_shift_sub(inv_mix(s_r ^ rk));
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (start) st_nxt = (ready_r && !key_dirty) ? ST_PRE : ST_EXP;
      ST_EXP:  if (cnt_r == AW'(ROUND_COUNT)) st_nxt = ST_PRE;
      ST_PRE:  st_nxt = ST_RND;
      ST_RND:  if ((!dir && cnt_r == AW'(ROUND_COUNT - 1)) || (dir && cnt_r == AW'(1)))
                 st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ready_r <= 1'b0;
      done_r <= 1'b0;
      fwd_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == ST_FIN);
      fwd_r <= we && (wa == ra);
      fwd_d_r <= wd;
      if (key_dirty) ready_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (start) s_r <= blk;
          if (start) begin
            w_r <= key;
            rc_r <= 8'h01;
          end
          if (start && !(ready_r && !key_dirty)) ready_r <= 1'b0;
        end
        ST_EXP: begin
          // Advance the window every second entry
          if (cnt_r[0]) begin
            w_r <= {nl, nh};
            rc_r <= xt(rc_r);
          end
          if (cnt_r == AW'(ROUND_COUNT)) begin
            ready_r <= 1'b1;
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        ST_PRE: begin
          // Initial key addition; decrypt's first step is a plain inverse shift/sub
          s_r <= dir ? inv_shift_sub(s_r ^ rk) : (s_r ^ rk);
          cnt_r <= dir ? AW'(ROUND_COUNT - 1) : AW'(1);
        end
        ST_RND: begin
          s_r <= dir ? dec_r : enc_r;
          cnt_r <= dir ? cnt_r - AW'(1) : cnt_r + AW'(1);
        end
        ST_FIN: begin
          s_r <= dir ? (s_r ^ rk) : (sub_shift(s_r) ^ rk);
        end
        default: ;
      endcase
    end
  end

  // Finish pulse follows the last round, when the state holds the result
  assign busy = (st_r != ST_IDLE);
  assign done = done_r;
  assign res = s_r;

endmodule

FILE: tb/sv/aes256_cbc_checker.sv
module aes256_cbc_checker
  import aes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_func,
  input  logic [63:0]           in_block_hi,
  input  logic [63:0]           in_block_lo,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [63:0]           out_out_hi,
  input  logic [63:0]           out_out_lo,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NR = 14;

  logic [63:0]  key_words [4];
  logic         decrypt_mode;
  logic [127:0] chain_reg;
  logic [127:0] sched [NR+1];
  logic         sched_valid;
  logic [127:0] expected_blocks [$];

  byte unsigned fwd_tab [256];
  byte unsigned rev_tab [256];

  function automatic byte unsigned dbl8(byte unsigned x);
    return byte'((x << 1) ^ ((x & 8'h80) != 0 ? 8'h1B : 8'h00));
  endfunction

  function automatic byte unsigned gmul(byte unsigned a, byte unsigned b);
    byte unsigned p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = dbl8(a);
      b = b >> 1;
    end
    return p;
  endfunction

  // Build S-box from the field inverse and the affine map.
  initial begin
    byte unsigned inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      for (int y = 1; y < 256; y++) begin
        if (gmul(byte'(x), byte'(y)) == 1) inv = byte'(y);
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_tab[x] = s;
      rev_tab[s] = byte'(x);
    end
  end

  function automatic byte unsigned bget(logic [127:0] b, int i);
    return b[127-8*i -: 8];
  endfunction

  task automatic expand_key();
    logic [31:0] w [4*(NR+1)];
    logic [31:0] t;
    byte unsigned rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = key_words[i/2][63-32*(i%2) -: 32];
    for (int i = 8; i < 4*(NR+1); i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_tab[t[31:24]] ^ rc, fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
        rc = dbl8(rc);
      end else if (i % 8 == 4) begin
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r <= NR; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    sched_valid = 1'b1;
  endtask

  function automatic logic [127:0] mix_cols(logic [127:0] s, bit inverse);
    logic [127:0] r;
    byte unsigned m [4];
    byte unsigned acc;
    if (inverse) begin
      m[0] = 8'h0E; m[1] = 8'h0B; m[2] = 8'h0D; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc ^= gmul(bget(s, 4*c+k), m[(k-w+4)%4]);
        r[127-8*(4*c+w) -: 8] = acc;
      end
    end
    return r;
  endfunction

  // One round step: substitute, shift rows, optional column mix.
  function automatic logic [127:0] round_fn(logic [127:0] s, bit inverse, bit do_mix);
    logic [127:0] r;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        src = inverse ? (c - w + 4) % 4 : (c + w) % 4;
        r[127-8*(4*c+w) -: 8] = inverse ? rev_tab[bget(s, 4*src+w)] : fwd_tab[bget(s, 4*src+w)];
      end
    end
    if (!do_mix) return r;
    return mix_cols(r, inverse);
  endfunction

  function automatic logic [127:0] encipher(logic [127:0] s);
    s ^= sched[0];
    for (int r = 1; r < NR; r++) s = round_fn(s, 0, 1) ^ sched[r];
    return round_fn(s, 0, 0) ^ sched[NR];
  endfunction

  function automatic logic [127:0] decipher(logic [127:0] s);
    s = round_fn(s ^ sched[NR], 1, 0);
    for (int r = NR-1; r > 0; r--) s = round_fn(mix_cols(s ^ sched[r], 1), 1, 0);
    return s ^ sched[0];
  endfunction

  assign pending_count = expected_blocks.size();

  // Track config, predict accepted words, compare results.
  always @(posedge clk) begin
    logic [127:0] blk, res, got, want;
    if (!rst_n) begin
      key_words = '{default: '0};
      decrypt_mode = 1'b0;
      chain_reg = '0;
      sched_valid = 1'b0;
      expected_blocks.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index) inside
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_words[cfg_index[1:0]] = cfg_data;
            sched_valid = 1'b0;
          end
          REG_DIR: decrypt_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        blk = {in_block_hi, in_block_lo};
        if (in_func == FUNC_IV) begin
          chain_reg = blk;
          if (!decrypt_mode) expected_blocks.push_back(blk);
        end else begin
          if (!sched_valid) expand_key();
          if (!decrypt_mode) begin
            res = encipher(blk ^ chain_reg);
            chain_reg = res;
          end else begin
            res = decipher(blk) ^ chain_reg;
            chain_reg = blk;
          end
          expected_blocks.push_back(res);
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_out_hi, out_out_lo};
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (got[127:64] !== want[127:64]) begin
            $display("%0t: out_hi mismatch: expected %h, actual %h", $time,
                     want[127:64], got[127:64]);
            fail_count++;
          end
          if (got[63:0] !== want[63:0]) begin
            $display("%0t: out_lo mismatch: expected %h, actual %h", $time,
                     want[63:0], got[63:0]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/aes256_cbc_cipher_test.sv
module aes256_cbc_cipher_test;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_func = FUNC_IV;
  logic [63:0]           in_block_hi = '0;
  logic [63:0]           in_block_lo = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [63:0]           out_out_hi;
  logic [63:0]           out_out_lo;
  int                    fail_count;
  int                    pending_count;
  longint                cycle_count = 0;
  bit                    hold_off_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aes256_cbc_cipher DUT (.*);

  aes256_cbc_checker checker_inst (.*);

  // Abort on a runaway run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall: random per word, with one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one word and hold it until accepted, after the given gap.
  task automatic send_word(logic func, logic [63:0] hi, logic [63:0] lo, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_block_hi <= hi;
    in_block_lo <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Let the block drain, then leave time for a word still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_key(bit [1:0] kind);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        2'd0: cfg_write(CFG_IDX_W'(i), '0);
        2'd1: cfg_write(CFG_IDX_W'(i), '1);
        default: cfg_write(CFG_IDX_W'(i), {$urandom, $urandom});
      endcase
    end
  endtask

  initial begin
    int gap;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no IV after reset, zero key, extreme blocks, both directions.
    send_word(FUNC_DATA, '0, '0, 0);
    send_word(FUNC_DATA, '1, '1, 0);
    send_word(FUNC_IV, '1, '0, 0);
    send_word(FUNC_DATA, 64'h0011223344556677, 64'h8899AABBCCDDEEFF, 0);
    drain();
    cfg_write(REG_KEY0, 64'h0001020304050607);
    cfg_write(REG_KEY1, 64'h08090A0B0C0D0E0F);
    cfg_write(REG_KEY2, 64'h1011121314151617);
    cfg_write(REG_KEY3, 64'h18191A1B1C1D1E1F);
    send_word(FUNC_IV, '0, '0, 0);
    send_word(FUNC_DATA, 64'h0011223344556677, 64'h8899AABBCCDDEEFF, 0);
    drain();
    cfg_write(REG_DIR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(FUNC_IV, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 0);
    send_word(FUNC_DATA, 64'h8EA2B7CA516745BF, 64'hEAFC49904B496089, 0);
    send_word(FUNC_DATA, '1, '0, 0);
    drain();
    // Out-of-range index and a mid-stream key change.
    cfg_write(3'd5, '1);
    cfg_write(3'd7, '1);
    cfg_write(REG_KEY2, '1);
    send_word(FUNC_DATA, '0, '1, 0);
    drain();
    load_key(2'd1);
    cfg_write(REG_DIR, 64'hFFFF_FFFF_FFFF_FFFE);
    send_word(FUNC_DATA, '1, '1, 0);
    drain();

    // Random phases: IV then chained blocks under a new setting.
    for (int ph = 0; ph < 40; ph++) begin
      if (ph % 3 == 0) load_key(2'($urandom_range(0, 2)));
      else if ($urandom_range(0, 1)) cfg_write(CFG_IDX_W'($urandom_range(0, 3)), rand64());
      cfg_write(REG_DIR, {$urandom, $urandom});
      if ($urandom_range(0, 7) == 0) cfg_write(CFG_IDX_W'($urandom_range(5, 7)), rand64());
      if (ph == 20) hold_off_req = 1'b1;
      for (int n = 0; n < 48; n++) begin
        gap = (ph == 20) ? 0 : rand_gap();
        if (n == 0 || $urandom_range(0, 15) == 0) send_word(FUNC_IV, rand64(), rand64(), gap);
        else send_word(FUNC_DATA, rand64(), rand64(), gap);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: aes256_cbc_cipher.f
design/aes_pkg.sv
design/aes_ram.sv
design/aes_cbc_core.sv
design/aes256_cbc_cipher.sv
tb/sv/aes256_cbc_checker.sv
tb/sv/aes256_cbc_cipher_test.sv
